// ----- hdl/tnrc_pkg.sv -----
// shared types, constants and the control store for the thermal rc step block
// used by tnrc_datapath and three_node_thermal_rc_step_top; no dependencies
`default_nettype none

package tnrc_pkg;

   // field and datapath widths
   localparam int TEMP_W       = 18;
   localparam int DIFF_W       = TEMP_W + 1;
   localparam int POWER_W      = 19;
   localparam int DT_W         = 21;
   localparam int COND_W       = 18;
   localparam int ICAP_W       = 24;
   localparam int OPA_W        = 38;                 // heat flow, net flow, energy
   localparam int OPB_W        = 18;                 // unsigned multiplier chunk
   localparam int CHUNK_W      = OPB_W;
   localparam int PROD_W       = OPA_W + OPB_W + 1;
   localparam int ACC_W        = 62;
   localparam int FLOW_SHIFT   = 16;                 // 2^-8 W to 2^-24 W
   localparam int ENERGY_SHIFT = 24;                 // 2^-44 J to 2^-20 J
   localparam int DK_SHIFT     = 32;                 // 2^-40 K to 2^-8 K
   localparam int SUM_W        = ACC_W - DK_SHIFT + 1;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;
   localparam int STEP_W       = 4;
   localparam int NODE_W       = 2;
   localparam int NODES        = 3;

   localparam logic [NODE_W-1:0] NODE_WIND  = 2'd0;
   localparam logic [NODE_W-1:0] NODE_HOUSE = 2'd1;
   localparam logic [NODE_W-1:0] NODE_BODY  = 2'd2;

   localparam logic signed [SUM_W-1:0] TEMP_MIN = -31'sd10240;
   localparam logic signed [SUM_W-1:0] TEMP_MAX = 31'sd76800;

   // reset values of the registers and the node temperatures
   localparam logic [COND_W-1:0] COND_WH_RESET = 18'd14168;
   localparam logic [COND_W-1:0] COND_HB_RESET = 18'd65536;
   localparam logic [COND_W-1:0] COND_BE_RESET = 18'd8192;
   localparam logic [ICAP_W-1:0] ICAP_W_RESET  = 24'd2857731;
   localparam logic [ICAP_W-1:0] ICAP_H_RESET  = 24'd63183;
   localparam logic [ICAP_W-1:0] ICAP_B_RESET  = 24'd839;
   localparam logic [TEMP_W-1:0] AMBIENT_RESET = 18'd6400;
   localparam logic [TEMP_W-1:0] TEMP_RESET    = 18'd6400;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COND_WH,
      CSR_COND_HB,
      CSR_COND_BE,
      CSR_ICAP_W,
      CSR_ICAP_H,
      CSR_ICAP_B,
      CSR_AMBIENT
   } csr_index_type;

   typedef struct packed {
      logic [COND_W-1:0] cond_wh;
      logic [COND_W-1:0] cond_hb;
      logic [COND_W-1:0] cond_be;
      logic [ICAP_W-1:0] icap_w;
      logic [ICAP_W-1:0] icap_h;
      logic [ICAP_W-1:0] icap_b;
      logic [TEMP_W-1:0] ambient;
   } cfg_type;

   typedef enum logic [1:0] {A_DIFF, A_NET, A_ENERGY} a_sel_type;
   typedef enum logic [2:0] {B_COND, B_DT_LO, B_DT_HI, B_ICAP_LO, B_ICAP_HI} b_sel_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_SHIFT_ADD} acc_op_type;
   typedef enum logic [1:0] {WB_NONE, WB_Q, WB_NETS, WB_TEMP} wb_type;

   // one control word of the microprogram
   typedef struct packed {
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      logic              use_loop;   // node fields come from the loop counter
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] wb_node;
      acc_op_type        acc_op;
      wb_type            wb;
      logic              loop_back;  // jump to target unless on the last node
      logic [STEP_W-1:0] target;
      logic              done;
   } ctrl_word_type;

   // control handed to the datapath, nodes already resolved
   typedef struct packed {
      logic              start;
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      logic [NODE_W-1:0] mul_node;
      logic [NODE_W-1:0] wb_node;
      acc_op_type        acc_op;
      wb_type            wb;
   } dp_ctrl_type;

   localparam logic [STEP_W-1:0] STEP_LOOP = 4'd5;

   localparam ctrl_word_type CW_NOP = '{
      a_sel: A_DIFF, b_sel: B_COND, use_loop: 1'b0, node: NODE_WIND,
      wb_node: NODE_WIND, acc_op: ACC_HOLD, wb: WB_NONE, loop_back: 1'b0,
      target: '0, done: 1'b0
   };

   // control store: heat flows, net flows, then per node dt and 1/C products
   function automatic ctrl_word_type ctrl_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = CW_NOP;
      case (step)
         4'd0: begin
            cw.node = NODE_WIND;
         end
         4'd1: begin
            cw.node    = NODE_HOUSE;
            cw.wb      = WB_Q;
            cw.wb_node = NODE_WIND;
         end
         4'd2: begin
            cw.node    = NODE_BODY;
            cw.wb      = WB_Q;
            cw.wb_node = NODE_HOUSE;
         end
         4'd3: begin
            cw.wb      = WB_Q;
            cw.wb_node = NODE_BODY;
         end
         4'd4: begin
            cw.wb = WB_NETS;
         end
         4'd5: begin
            cw.use_loop = 1'b1;
            cw.a_sel    = A_NET;
            cw.b_sel    = B_DT_HI;
         end
         4'd6: begin
            cw.use_loop = 1'b1;
            cw.a_sel    = A_NET;
            cw.b_sel    = B_DT_LO;
            cw.acc_op   = ACC_LOAD;
         end
         4'd7: begin
            cw.acc_op = ACC_SHIFT_ADD;
         end
         4'd8: begin
            cw.use_loop = 1'b1;
            cw.a_sel    = A_ENERGY;
            cw.b_sel    = B_ICAP_HI;
         end
         4'd9: begin
            cw.use_loop = 1'b1;
            cw.a_sel    = A_ENERGY;
            cw.b_sel    = B_ICAP_LO;
            cw.acc_op   = ACC_LOAD;
         end
         4'd10: begin
            cw.acc_op = ACC_SHIFT_ADD;
         end
         4'd11: begin
            cw.use_loop  = 1'b1;
            cw.wb        = WB_TEMP;
            cw.loop_back = 1'b1;
            cw.target    = STEP_LOOP;
         end
         4'd12: begin
            cw.done = 1'b1;
         end
         default: begin
            cw.done = 1'b1;
         end
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/tnrc_datapath.sv -----
// datapath of the thermal rc step: one shared 38x18 multiplier, accumulator,
// heat flow and node temperature registers; depends on tnrc_pkg
`default_nettype none

module tnrc_datapath import tnrc_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dp_ctrl_type               ctrl,
   input  wire cfg_type                   cfg,
   input  wire logic signed [POWER_W-1:0] heat_power,
   input  wire logic        [DT_W-1:0]    step_time,
   output logic signed      [TEMP_W-1:0]  winding_temp,
   output logic signed      [TEMP_W-1:0]  housing_temp,
   output logic signed      [TEMP_W-1:0]  body_temp,
   output logic                           saturated
);

   logic signed [TEMP_W-1:0]  temp_ff [NODES];
   logic signed [TEMP_W-1:0]  temp_in [NODES];
   logic signed [DIFF_W-1:0]  diff_ff [NODES];
   logic signed [DIFF_W-1:0]  diff_in [NODES];
   logic signed [OPA_W-1:0]   q_ff    [NODES];
   logic signed [OPA_W-1:0]   net_ff  [NODES];
   logic signed [OPA_W-1:0]   net_in  [NODES];
   logic signed [POWER_W-1:0] power_ff;
   logic        [DT_W-1:0]    dt_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic                      sat_ff;
   logic                      sat_in;

   logic signed [OPA_W-1:0]   opa;
   logic        [OPB_W-1:0]   opb;
   logic signed [OPB_W:0]     opb_s;
   logic        [COND_W-1:0]  cond_sel;
   logic        [ICAP_W-1:0]  icap_sel;
   logic signed [OPA_W-1:0]   power_ext;
   logic signed [SUM_W-1:0]   t_ext;
   logic signed [SUM_W-1:0]   dk_ext;
   logic signed [SUM_W-1:0]   rnd_ext;
   logic signed [SUM_W-1:0]   t_sum;
   logic signed [TEMP_W-1:0]  t_new;
   logic                      t_clamped;

   always_comb begin
      case (ctrl.mul_node)
         NODE_HOUSE: begin
            cond_sel = cfg.cond_hb;
            icap_sel = cfg.icap_h;
         end
         NODE_BODY: begin
            cond_sel = cfg.cond_be;
            icap_sel = cfg.icap_b;
         end
         default: begin
            cond_sel = cfg.cond_wh;
            icap_sel = cfg.icap_w;
         end
      endcase

      case (ctrl.a_sel)
         A_DIFF:   opa = OPA_W'(diff_ff[ctrl.mul_node]);
         A_NET:    opa = net_ff[ctrl.mul_node];
         A_ENERGY: opa = acc_ff[ACC_W-1:ENERGY_SHIFT];
         default:  opa = '0;
      endcase

      case (ctrl.b_sel)
         B_COND:    opb = cond_sel;
         B_DT_LO:   opb = dt_ff[CHUNK_W-1:0];
         B_DT_HI:   opb = OPB_W'(dt_ff[DT_W-1:CHUNK_W]);
         B_ICAP_LO: opb = icap_sel[CHUNK_W-1:0];
         B_ICAP_HI: opb = OPB_W'(icap_sel[ICAP_W-1:CHUNK_W]);
         default:   opb = '0;
      endcase

      opb_s   = $signed({1'b0, opb});
      prod_in = opa * opb_s;

      case (ctrl.acc_op)
         ACC_LOAD:      acc_in = ACC_W'(prod_ff);
         ACC_SHIFT_ADD: acc_in = (acc_ff <<< CHUNK_W) + ACC_W'(prod_ff);
         default:       acc_in = acc_ff;
      endcase
   end

   // net flows in 2^-24 W, power scaled up to the same unit
   always_comb begin
      power_ext = {{(OPA_W-POWER_W-FLOW_SHIFT){power_ff[POWER_W-1]}}, power_ff,
                   {FLOW_SHIFT{1'b0}}};
      net_in[0] = power_ext - q_ff[0];
      net_in[1] = q_ff[0] - q_ff[1];
      net_in[2] = q_ff[1] - q_ff[2];
   end

   // round dk to 1/256 K with ties upward, add to the node and clamp
   always_comb begin
      t_ext   = SUM_W'(temp_ff[ctrl.wb_node]);
      dk_ext  = SUM_W'($signed(acc_ff[ACC_W-1:DK_SHIFT]));
      rnd_ext = {{(SUM_W-1){1'b0}}, acc_ff[DK_SHIFT-1]};
      t_sum   = t_ext + dk_ext + rnd_ext;
      t_clamped = 1'b1;
      if (t_sum < TEMP_MIN) begin
         t_new = TEMP_W'(TEMP_MIN);
      end else if (t_sum > TEMP_MAX) begin
         t_new = TEMP_W'(TEMP_MAX);
      end else begin
         t_new     = TEMP_W'(t_sum);
         t_clamped = 1'b0;
      end
   end

   always_comb begin
      diff_in[0] = DIFF_W'(temp_ff[0]) - DIFF_W'(temp_ff[1]);
      diff_in[1] = DIFF_W'(temp_ff[1]) - DIFF_W'(temp_ff[2]);
      diff_in[2] = DIFF_W'(temp_ff[2]) - DIFF_W'($signed(cfg.ambient));
      for (int n = 0; n < NODES; n++) begin
         temp_in[n] = temp_ff[n];
      end
      sat_in = sat_ff;
      if (ctrl.start) begin
         sat_in = 1'b0;
      end else if (ctrl.wb == WB_TEMP) begin
         temp_in[ctrl.wb_node] = t_new;
         sat_in                = sat_ff | t_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NODES; n++) begin
            temp_ff[n] <= TEMP_RESET;
         end
         sat_ff <= 1'b0;
      end else begin
         for (int n = 0; n < NODES; n++) begin
            temp_ff[n] <= temp_in[n];
         end
         sat_ff <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctrl.start) begin
         power_ff <= heat_power;
         dt_ff    <= step_time;
         for (int n = 0; n < NODES; n++) begin
            diff_ff[n] <= diff_in[n];
         end
      end
      if (ctrl.wb == WB_Q) begin
         q_ff[ctrl.wb_node] <= prod_ff[OPA_W-1:0];
      end
      if (ctrl.wb == WB_NETS) begin
         for (int n = 0; n < NODES; n++) begin
            net_ff[n] <= net_in[n];
         end
      end
   end

   assign winding_temp = temp_ff[0];
   assign housing_temp = temp_ff[1];
   assign body_temp    = temp_ff[2];
   assign saturated    = sat_ff;

endmodule

`default_nettype wire

// ----- hdl/three_node_thermal_rc_step_top.sv -----
// three-node thermal rc estimator: one forward euler step per transaction
// holds the register bank, the microprogram sequencer and the result register
// depends on tnrc_pkg and tnrc_datapath
//
// usage:
//   req channel (valid/ready) carries heat_power and step_time; rsp channel
//   (valid/ready) returns the three new temperatures and the saturated flag
//   csr port writes one register per cycle with csr_write_en, no read-back
//   rsp_valid is registered and rises when the sequencer leaves its last step
//   requests are taken one at a time, the pace set by the microprogram
//   driving a single shared 38x18 multiplier through 15 partial products
//   (three heat flows, then per node two step-time and two 1/C products)
//   the result register frees the datapath: the next request is taken while
//   a result waits; if the receiver stalls that long, the sequencer holds on
//   its final step until the result register is taken
//   reset: registers return to the default motor set, all three nodes to
//   25 degC, both channels empty; no clearing pass is needed
`default_nettype none

module three_node_thermal_rc_step_top import tnrc_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [POWER_W-1:0]    req_heat_power,
   input  wire logic        [DT_W-1:0]       req_step_time,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed      [TEMP_W-1:0]     rsp_winding_temp,
   output logic signed      [TEMP_W-1:0]     rsp_housing_temp,
   output logic signed      [TEMP_W-1:0]     rsp_body_temp,
   output logic                              rsp_saturated,
   input  wire logic                         csr_write_en,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic                     busy_ff;
   logic                     busy_in;
   logic [STEP_W-1:0]        step_ff;
   logic [STEP_W-1:0]        step_in;
   logic [NODE_W-1:0]        node_ff;
   logic [NODE_W-1:0]        node_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [TEMP_W-1:0] rsp_wind_ff;
   logic signed [TEMP_W-1:0] rsp_house_ff;
   logic signed [TEMP_W-1:0] rsp_body_ff;
   logic                     rsp_sat_ff;

   ctrl_word_type            cw;
   dp_ctrl_type              dp_ctrl;
   logic                     accept;
   logic                     stall;
   logic                     finish;
   logic signed [TEMP_W-1:0] dp_wind;
   logic signed [TEMP_W-1:0] dp_house;
   logic signed [TEMP_W-1:0] dp_body;
   logic                     dp_sat;

   // register bank
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_COND_WH: cfg_in.cond_wh = csr_wdata[COND_W-1:0];
            CSR_COND_HB: cfg_in.cond_hb = csr_wdata[COND_W-1:0];
            CSR_COND_BE: cfg_in.cond_be = csr_wdata[COND_W-1:0];
            CSR_ICAP_W:  cfg_in.icap_w  = csr_wdata[ICAP_W-1:0];
            CSR_ICAP_H:  cfg_in.icap_h  = csr_wdata[ICAP_W-1:0];
            CSR_ICAP_B:  cfg_in.icap_b  = csr_wdata[ICAP_W-1:0];
            CSR_AMBIENT: cfg_in.ambient = csr_wdata[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{cond_wh: COND_WH_RESET, cond_hb: COND_HB_RESET,
                     cond_be: COND_BE_RESET, icap_w: ICAP_W_RESET,
                     icap_h: ICAP_H_RESET, icap_b: ICAP_B_RESET,
                     ambient: AMBIENT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   assign cw        = ctrl_rom(step_ff);
   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign stall     = cw.done && rsp_valid_ff && !rsp_ready;
   assign finish    = busy_ff && cw.done && !stall;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      node_in = node_ff;
      if (!busy_ff) begin
         if (accept) begin
            busy_in = 1'b1;
            step_in = '0;
            node_in = NODE_WIND;
         end
      end else if (!stall) begin
         if (cw.done) begin
            busy_in = 1'b0;
         end else if (cw.loop_back && node_ff != NODE_BODY) begin
            step_in = cw.target;
            node_in = node_ff + NODE_W'(1);
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      dp_ctrl.start    = accept;
      dp_ctrl.a_sel    = cw.a_sel;
      dp_ctrl.b_sel    = cw.b_sel;
      dp_ctrl.mul_node = cw.use_loop ? node_ff : cw.node;
      dp_ctrl.wb_node  = cw.use_loop ? node_ff : cw.wb_node;
      dp_ctrl.acc_op   = busy_ff ? cw.acc_op : ACC_HOLD;
      dp_ctrl.wb       = busy_ff ? cw.wb : WB_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         node_ff      <= NODE_WIND;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (finish) begin
         rsp_wind_ff  <= dp_wind;
         rsp_house_ff <= dp_house;
         rsp_body_ff  <= dp_body;
         rsp_sat_ff   <= dp_sat;
      end
   end

   tnrc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (dp_ctrl),
      .cfg          (cfg_ff),
      .heat_power   (req_heat_power),
      .step_time    (req_step_time),
      .winding_temp (dp_wind),
      .housing_temp (dp_house),
      .body_temp    (dp_body),
      .saturated    (dp_sat)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_winding_temp = rsp_wind_ff;
   assign rsp_housing_temp = rsp_house_ff;
   assign rsp_body_temp    = rsp_body_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

`default_nettype wire
